// File: hw/rtl/hufdec_pkg.sv
// Shared types and codes for the Huffman tree builder / decoder.
// No dependencies; used by huffman_tree_build_and_decode.
package hufdec_pkg;

  // Field widths fixed by the item format
  localparam int unsigned OpcodeW   = 2;
  localparam int unsigned SymIdxW   = 8;
  localparam int unsigned FreqInW   = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 32;
  localparam int unsigned InTdataW  = 48;  // 8 + 32 + 1, padded to bytes
  localparam int unsigned OutTdataW = 8;
  localparam int unsigned WeightExt = 8;   // headroom bits on merged weights

  typedef enum logic [OpcodeW-1:0] {
    OP_LOAD_FREQ = 2'd0,
    OP_BUILD     = 2'd1,
    OP_CODE_BIT  = 2'd2,
    OP_UNUSED    = 2'd3
  } opcode_e;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_FILL_RD  = 8'b0000_0010,
    ST_FILL_CHK = 8'b0000_0100,
    ST_SCAN_RD  = 8'b0000_1000,
    ST_SCAN_CHK = 8'b0001_0000,
    ST_MERGE    = 8'b0010_0000,
    ST_DEC_A    = 8'b0100_0000,
    ST_DEC_B    = 8'b1000_0000
  } state_e;

endpackage

// File: hw/rtl/huffman_tree_build_and_decode.sv
// Huffman tree builder and bit-serial decoder, top level.
// Depends on hufdec_pkg (types, opcodes, field widths).

// Takes items of three kinds. A frequency load writes one entry of the
// byte-frequency table. A build item forms the Huffman tree with one
// sequencer and one shared compare/add datapath: a fill sweep reads and
// checks each symbol in turn and places every non-zero symbol into the
// forest, then each merge is one pass over the first n slots, each slot
// taking a memory read and then a compare against the two lightest so far,
// followed by a merge step. A code-bit item reads the node memory once or
// twice and may produce one output item; it waits further only while a
// previous output item is still held.
// The block is not ready while an item is being worked on. No clearing pass
// runs after reset: the frequency table and slot occupancy carry valid bits.
module huffman_tree_build_and_decode #(
  parameter int unsigned NUM_SYMBOLS = 256,
  parameter int unsigned FREQ_WIDTH  = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hufdec_pkg::CountW-1:0]    cfg_wdata_i,    // symbol_count
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [7:0] symbol_index, [39:8] frequency, [40] code_bit, [47:41] zero
  input  logic [hufdec_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // [1:0] opcode
  input  logic [hufdec_pkg::OpcodeW-1:0]   s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [7:0] decoded_byte
  output logic [hufdec_pkg::OutTdataW-1:0] m_axis_tdata_o,
  output logic                             m_axis_tlast_o  // last_byte
);

  localparam int unsigned SW    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int unsigned NODES = 2 * NUM_SYMBOLS - 1;
  localparam int unsigned NW    = $clog2(NODES);
  localparam int unsigned WW    = FREQ_WIDTH + hufdec_pkg::WeightExt;
  localparam int unsigned LW    = hufdec_pkg::ByteW + 1;       // leaf mark + byte
  localparam int unsigned EW    = LW + 2 * NW;                 // node entry

  // ---------------------------------------------------------------- input fields
  logic [hufdec_pkg::SymIdxW-1:0] in_sym;
  logic [FREQ_WIDTH-1:0]          in_freq;
  logic                           in_bit;
  hufdec_pkg::opcode_e            in_op;
  logic                           in_acc;

  assign in_sym  = s_axis_tdata_i[7:0];
  assign in_freq = s_axis_tdata_i[8 +: FREQ_WIDTH];
  assign in_bit  = s_axis_tdata_i[40];
  assign in_op   = hufdec_pkg::opcode_e'(s_axis_tuser_i);

  // ---------------------------------------------------------------- state
  hufdec_pkg::state_e state_q, state_d;
  logic [hufdec_pkg::CountW-1:0] sym_count_q, sym_count_d;
  logic [hufdec_pkg::CountW-1:0] emitted_q, emitted_d;
  logic [NW-1:0] root_q, root_d, cursor_q, cursor_d, cur_q, cur_d, next_q, next_d;
  logic          tree_valid_q, tree_valid_d;
  logic          bit_q, bit_d;
  logic [SW-1:0] fill_s_q, fill_s_d, scan_s_q, scan_s_d;
  logic [SW:0]   n_q, n_d;
  // two lightest trees of the current pass, and first empty slot seen
  logic          b1v_q, b1v_d, b2v_q, b2v_d, fev_q, fev_d;
  logic [SW-1:0] b1s_q, b1s_d, b2s_q, b2s_d, fes_q, fes_d;
  logic [NW-1:0] b1n_q, b1n_d, b2n_q, b2n_d;
  logic [WW-1:0] b1w_q, b1w_d, b2w_q, b2w_d;
  logic          out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [hufdec_pkg::ByteW-1:0] out_byte_q, out_byte_d;

  // valid bits
  logic [NUM_SYMBOLS-1:0] fv_q, fv_d, used_q, used_d;

  // ---------------------------------------------------------------- memories
  logic [FREQ_WIDTH-1:0] freq_mem [NUM_SYMBOLS];
  logic [NW-1:0]         slot_node_mem [NUM_SYMBOLS];
  logic [WW-1:0]         slot_w_mem [NUM_SYMBOLS];
  logic [EW-1:0]         node_mem [NODES];

  logic [FREQ_WIDTH-1:0] freq_rd_q;
  logic                  fv_rd_q;
  logic [NW-1:0]         slot_node_rd_q;
  logic [WW-1:0]         slot_w_rd_q;
  logic [EW-1:0]         node_rd_q;

  logic                  freq_we;
  logic [SW-1:0]         freq_waddr;
  logic                  slot_we;
  logic [SW-1:0]         slot_waddr;
  logic [NW-1:0]         slot_wnode;
  logic [WW-1:0]         slot_wweight;
  logic                  node_we;
  logic [NW-1:0]         node_waddr, node_raddr;
  logic [EW-1:0]         node_wdata;
  logic [SW-1:0]         slot_raddr;

  // node entry fields
  logic          rd_leaf;
  logic [hufdec_pkg::ByteW-1:0] rd_byte;
  logic [NW-1:0] rd_left, rd_right, rd_child;
  assign rd_leaf  = node_rd_q[EW-1];
  assign rd_byte  = node_rd_q[2*NW +: hufdec_pkg::ByteW];
  assign rd_right = node_rd_q[NW +: NW];
  assign rd_left  = node_rd_q[0 +: NW];
  assign rd_child = bit_q ? rd_right : rd_left;

  logic out_free;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == hufdec_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // shared compare / add unit
  logic          w_lt_b1, w_lt_b2;
  logic [WW-1:0] w_sum;
  logic [SW-1:0] low_pair, low_empty;
  assign w_lt_b1   = slot_w_rd_q < b1w_q;
  assign w_lt_b2   = slot_w_rd_q < b2w_q;
  assign w_sum     = b1w_q + b2w_q;
  assign low_pair  = (b1s_q < b2s_q) ? b1s_q : b2s_q;
  assign low_empty = (fev_q && (fes_q < low_pair)) ? fes_q : low_pair;

  assign slot_raddr = scan_s_q;

  always_comb begin
    node_raddr = cursor_q;
    if (state_q == hufdec_pkg::ST_DEC_B) begin
      node_raddr = cur_q;
    end else if (state_q == hufdec_pkg::ST_DEC_A && !rd_leaf) begin
      node_raddr = rd_child;
    end
  end

  always_comb begin
    state_d      = state_q;
    sym_count_d  = sym_count_q;
    emitted_d    = emitted_q;
    root_d       = root_q;
    cursor_d     = cursor_q;
    cur_d        = cur_q;
    next_d       = next_q;
    tree_valid_d = tree_valid_q;
    bit_d        = bit_q;
    fill_s_d     = fill_s_q;
    scan_s_d     = scan_s_q;
    n_d          = n_q;
    b1v_d = b1v_q; b2v_d = b2v_q; fev_d = fev_q;
    b1s_d = b1s_q; b2s_d = b2s_q; fes_d = fes_q;
    b1n_d = b1n_q; b2n_d = b2n_q;
    b1w_d = b1w_q; b2w_d = b2w_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_last_d   = out_last_q;
    out_byte_d   = out_byte_q;
    fv_d         = fv_q;
    used_d       = used_q;
    freq_we      = 1'b0;
    freq_waddr   = in_sym[SW-1:0];
    slot_we      = 1'b0;
    slot_waddr   = n_q[SW-1:0];
    slot_wnode   = n_q[NW-1:0];
    slot_wweight = WW'(freq_rd_q);
    node_we      = 1'b0;
    node_waddr   = n_q[NW-1:0];
    node_wdata   = {1'b1, fill_s_q[SW-1:0] == fill_s_q ? hufdec_pkg::ByteW'(fill_s_q)
                                                      : hufdec_pkg::ByteW'(0),
                    {NW{1'b0}}, {NW{1'b0}}};

    if (cfg_we_i) begin
      sym_count_d = cfg_wdata_i;
    end

    case (state_q)
      hufdec_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            hufdec_pkg::OP_LOAD_FREQ: begin
              if ({1'b0, in_sym} < (hufdec_pkg::SymIdxW + 1)'(NUM_SYMBOLS)) begin
                freq_we            = 1'b1;
                fv_d[freq_waddr]   = 1'b1;
              end
            end
            hufdec_pkg::OP_BUILD: begin
              used_d   = '0;
              n_d      = '0;
              fill_s_d = '0;
              state_d  = hufdec_pkg::ST_FILL_RD;
            end
            hufdec_pkg::OP_CODE_BIT: begin
              bit_d = in_bit;
              if (tree_valid_q && (emitted_q < sym_count_q)) begin
                state_d = hufdec_pkg::ST_DEC_A;
              end
            end
            default: ;
          endcase
        end
      end

      hufdec_pkg::ST_FILL_RD: state_d = hufdec_pkg::ST_FILL_CHK;

      hufdec_pkg::ST_FILL_CHK: begin
        if (fv_rd_q && (freq_rd_q != '0)) begin
          node_we          = 1'b1;
          slot_we          = 1'b1;
          used_d[n_q[SW-1:0]] = 1'b1;
          n_d              = n_q + 1'b1;
        end
        if (fill_s_q == SW'(NUM_SYMBOLS - 1)) begin
          next_d   = NW'(n_d);
          scan_s_d = '0;
          b1v_d = 1'b0; b2v_d = 1'b0; fev_d = 1'b0;
          state_d  = hufdec_pkg::ST_SCAN_RD;
        end else begin
          fill_s_d = fill_s_q + 1'b1;
          state_d  = hufdec_pkg::ST_FILL_RD;
        end
      end

      hufdec_pkg::ST_SCAN_RD: begin
        state_d = (n_q == '0) ? hufdec_pkg::ST_MERGE : hufdec_pkg::ST_SCAN_CHK;
      end

      hufdec_pkg::ST_SCAN_CHK: begin
        if (used_q[scan_s_q]) begin
          if (!b1v_q || w_lt_b1) begin
            b2v_d = b1v_q; b2s_d = b1s_q; b2n_d = b1n_q; b2w_d = b1w_q;
            b1v_d = 1'b1;  b1s_d = scan_s_q; b1n_d = slot_node_rd_q;
            b1w_d = slot_w_rd_q;
          end else if (!b2v_q || w_lt_b2) begin
            b2v_d = 1'b1; b2s_d = scan_s_q; b2n_d = slot_node_rd_q;
            b2w_d = slot_w_rd_q;
          end
        end else if (!fev_q) begin
          fev_d = 1'b1;
          fes_d = scan_s_q;
        end
        if ({1'b0, scan_s_q} == n_q - 1'b1) begin
          state_d = hufdec_pkg::ST_MERGE;
        end else begin
          scan_s_d = scan_s_q + 1'b1;
          state_d  = hufdec_pkg::ST_SCAN_RD;
        end
      end

      hufdec_pkg::ST_MERGE: begin
        if (!b1v_q || !b2v_q) begin
          // empty table leaves no tree; a single tree left is the root
          tree_valid_d = b1v_q;
          if (b1v_q) begin
            root_d = b1n_q;
          end
          cursor_d  = b1v_q ? b1n_q : root_q;
          emitted_d = '0;
          state_d   = hufdec_pkg::ST_IDLE;
        end else begin
          node_we      = 1'b1;
          node_waddr   = next_q;
          node_wdata   = {{LW{1'b0}}, b2n_q, b1n_q};
          used_d[b1s_q] = 1'b0;
          used_d[b2s_q] = 1'b0;
          used_d[low_empty] = 1'b1;
          slot_we      = 1'b1;
          slot_waddr   = low_empty;
          slot_wnode   = next_q;
          slot_wweight = w_sum;
          next_d       = next_q + 1'b1;
          scan_s_d     = '0;
          b1v_d = 1'b0; b2v_d = 1'b0; fev_d = 1'b0;
          state_d      = hufdec_pkg::ST_SCAN_RD;
        end
      end

      hufdec_pkg::ST_DEC_A: begin
        if (rd_leaf) begin
          // single-symbol tree: the root itself is a leaf
          if (out_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = rd_byte;
            out_last_d  = (emitted_q + 1'b1) == sym_count_q;
            emitted_d   = emitted_q + 1'b1;
            cursor_d    = root_q;
            state_d     = hufdec_pkg::ST_IDLE;
          end
        end else begin
          cur_d   = rd_child;
          state_d = hufdec_pkg::ST_DEC_B;
        end
      end

      hufdec_pkg::ST_DEC_B: begin
        if (rd_leaf) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = rd_byte;
            out_last_d  = (emitted_q + 1'b1) == sym_count_q;
            emitted_d   = emitted_q + 1'b1;
            cursor_d    = root_q;
            state_d     = hufdec_pkg::ST_IDLE;
          end
        end else begin
          cursor_d = cur_q;
          state_d  = hufdec_pkg::ST_IDLE;
        end
      end

      default: state_d = hufdec_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    if (freq_we) begin
      freq_mem[freq_waddr] <= in_freq;
    end
    freq_rd_q <= freq_mem[fill_s_q];
    fv_rd_q   <= fv_q[fill_s_q];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_node_mem[slot_waddr] <= slot_wnode;
      slot_w_mem[slot_waddr]    <= slot_wweight;
    end
    slot_node_rd_q <= slot_node_mem[slot_raddr];
    slot_w_rd_q    <= slot_w_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rd_q <= node_mem[node_raddr];
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= hufdec_pkg::ST_IDLE;
      sym_count_q  <= '0;
      emitted_q    <= '0;
      root_q       <= '0;
      cursor_q     <= '0;
      tree_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      fv_q         <= '0;
      used_q       <= '0;
      n_q          <= '0;
      b1v_q        <= 1'b0;
      b2v_q        <= 1'b0;
      fev_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      sym_count_q  <= sym_count_d;
      emitted_q    <= emitted_d;
      root_q       <= root_d;
      cursor_q     <= cursor_d;
      tree_valid_q <= tree_valid_d;
      out_valid_q  <= out_valid_d;
      fv_q         <= fv_d;
      used_q       <= used_d;
      n_q          <= n_d;
      b1v_q        <= b1v_d;
      b2v_q        <= b2v_d;
      fev_q        <= fev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    next_q     <= next_d;
    bit_q      <= bit_d;
    fill_s_q   <= fill_s_d;
    scan_s_q   <= scan_s_d;
    b1s_q <= b1s_d; b2s_q <= b2s_d; fes_q <= fes_d;
    b1n_q <= b1n_d; b2n_q <= b2n_d;
    b1w_q <= b1w_d; b2w_q <= b2w_d;
    out_last_q <= out_last_d;
    out_byte_q <= out_byte_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------- checks
  a_emit_needs_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> tree_valid_q)
    else $error("output item without a built tree");

  a_last_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && out_last_q) |-> (emitted_q == sym_count_q))
    else $error("last marker does not match the emitted count");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hufdec_pkg::ST_SCAN_CHK) |-> ({1'b0, scan_s_q} < n_q))
    else $error("slot scan ran past the used slots");

endmodule
